// File: design/cfsg_pkg.sv
package cfsg_pkg;

	localparam int PHASE_TABLE_SIZE = 36;
	localparam int PHASE_W = $clog2(PHASE_TABLE_SIZE);
	localparam int PHASE_HALF = PHASE_TABLE_SIZE / 2;
	localparam int PHASE_SHIFT = 14;
	localparam int PHASE_RECIP = (1 << PHASE_SHIFT) / PHASE_TABLE_SIZE;

	localparam int SR_W = 17;
	localparam int BAUD_W = 14;
	localparam int STOP_W = 4;
	localparam int FRAME_W = 5;
	localparam int LEN_W = 16;
	localparam int DIV_W = 17;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam int FRAME_BASE = 9;
	localparam int DATA_BITS = 8;
	localparam int STEP_BASE = 44100;
	localparam int STEP_MAX = 255;
	localparam int LEN_MAX = 65535;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAUD_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BITS = 2'd2;

	localparam logic [SR_W-1:0] SR_RESET = 17'd44100;
	localparam logic [BAUD_W-1:0] BAUD_RESET = 14'd1200;
	localparam logic [STOP_W-1:0] STOP_RESET = 4'd3;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] SYM_SILENCE = 2'd0;
	localparam logic [1:0] SYM_TONE = 2'd1;
	localparam logic [1:0] SYM_DATA = 2'd2;

	localparam logic [3:0] SEG_START = 4'd0;
	localparam logic [3:0] SEG_STOP = 4'd9;

	localparam logic signed [15:0] LEVEL_POS = 16'sh7FFF;
	localparam logic signed [15:0] LEVEL_NEG = 16'sh8001;

	typedef struct packed {
		logic kind;
		logic [1:0] symbol;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic period_end;
		logic idle;
	} result_t;

	typedef enum logic [2:0] {
		OP_PER_SEC,
		OP_LEN,
		OP_BIT,
		OP_STEP_LO,
		OP_STEP_HI
	} div_op_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		div_op_t div_op;
		logic div_store;
		logic commit;
		logic tick;
	} cmd_t;

	typedef struct packed {
		logic item_kind;
		logic div_done;
		logic out_free;
	} status_t;

	function automatic logic [7:0] sat8(input logic [DIV_W-1:0] v);
		return (v > DIV_W'(STEP_MAX)) ? 8'(STEP_MAX) : v[7:0];
	endfunction

	// v mod table size, reciprocal estimate is low by at most one
	function automatic logic [PHASE_W-1:0] phase_mod(input logic [7:0] v);
		logic [23:0] prod;
		logic [7:0] q;
		logic [15:0] r;
		prod = 24'(v) * 24'(PHASE_RECIP);
		q = 8'(prod >> PHASE_SHIFT);
		r = 16'(v) - 16'(q) * 16'(PHASE_TABLE_SIZE);
		if (r >= 16'(PHASE_TABLE_SIZE)) begin
			r = r - 16'(PHASE_TABLE_SIZE);
		end
		return PHASE_W'(r);
	endfunction

endpackage

// File: design/cfsg_div.sv
module cfsg_div
	import cfsg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [DIV_W:0] shifted;
	logic [DIV_W+1:0] diff;
	logic ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff = {1'b0, shifted} - (DIV_W+2)'(dsr_q);
		ge = ~diff[DIV_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// File: design/cfsg_ctrl.sv
module cfsg_ctrl
	import cfsg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  status_t stat,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_DIV_START,
		S_DIV_WAIT,
		S_COMMIT
	} state_t;

	state_t state_q;
	div_op_t op_q;
	div_op_t op_next;

	always_comb begin
		case (op_q)
			OP_PER_SEC: op_next = OP_LEN;
			OP_LEN:     op_next = OP_BIT;
			OP_BIT:     op_next = OP_STEP_LO;
			OP_STEP_LO: op_next = OP_STEP_HI;
			default:    op_next = OP_STEP_HI;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = op_q;
		cmd.capture = (state_q == S_IDLE) && item_valid;
		cmd.tick = (state_q == S_TICK) && stat.out_free;
		cmd.div_start = (state_q == S_DIV_START);
		cmd.div_store = (state_q == S_DIV_WAIT) && stat.div_done;
		cmd.commit = (state_q == S_COMMIT);
	end

	assign item_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_PER_SEC;
		end else begin
			case (state_q)
				S_IDLE: begin
					op_q <= OP_PER_SEC;
					if (item_valid) begin
						state_q <= (stat.item_kind == KIND_TICK) ? S_TICK : S_DIV_START;
					end
				end
				S_TICK: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						if (op_q == OP_STEP_HI) begin
							state_q <= S_COMMIT;
						end else begin
							op_q <= op_next;
							state_q <= S_DIV_START;
						end
					end
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/cfsg_dp.sv
module cfsg_dp
	import cfsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  cmd_t                  cmd,
	output status_t               stat
);

	logic [SR_W-1:0] sample_rate_q;
	logic [BAUD_W-1:0] baud_rate_q;
	logic [STOP_W-1:0] stop_bits_q;

	item_t item_q;
	logic [BAUD_W-1:0] per_sec_q;
	logic [LEN_W-1:0] len_new_q;
	logic [LEN_W-1:0] bit_new_q;
	logic [PHASE_W-1:0] stl_new_q;
	logic [PHASE_W-1:0] sth_new_q;

	logic [PHASE_W-1:0] phase_q;
	logic [1:0] mode_q;
	logic [7:0] byte_q;
	logic [LEN_W-1:0] period_left_q;
	logic [LEN_W-1:0] spb_q;
	logic [LEN_W-1:0] sub_q;
	logic [3:0] seg_q;
	logic [PHASE_W-1:0] stl_q;
	logic [PHASE_W-1:0] sth_q;
	logic tone_latch_q;

	logic result_valid_q;
	result_t result_q;

	logic [FRAME_W-1:0] frame_bits;
	logic [DIV_W-1:0] dividend;
	logic [DIV_W-1:0] divisor;
	logic div_done;
	logic [DIV_W-1:0] div_quo;
	logic [7:0] step_sat;

	logic running;
	logic use_tone;
	logic use_high;
	logic [PHASE_W-1:0] step;
	logic [PHASE_W:0] phase_sum;
	logic [PHASE_W-1:0] phase_nxt;
	logic signed [15:0] level;

	assign cfg_ready = 1'b1;
	assign frame_bits = FRAME_W'(FRAME_BASE) + FRAME_W'(stop_bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SR_RESET;
			baud_rate_q <= BAUD_RESET;
			stop_bits_q <= STOP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAMPLE_RATE: sample_rate_q <= SR_W'(cfg_data);
				REG_BAUD_RATE:   baud_rate_q <= BAUD_W'(cfg_data);
				REG_STOP_BITS:   stop_bits_q <= STOP_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.div_op)
			OP_PER_SEC: begin
				dividend = DIV_W'(baud_rate_q);
				divisor = DIV_W'(frame_bits);
			end
			OP_LEN: begin
				dividend = DIV_W'(sample_rate_q);
				divisor = DIV_W'(per_sec_q);
			end
			OP_BIT: begin
				dividend = DIV_W'(len_new_q);
				divisor = DIV_W'(frame_bits);
			end
			OP_STEP_LO: begin
				dividend = DIV_W'(STEP_BASE);
				divisor = DIV_W'(sample_rate_q);
			end
			default: begin
				dividend = DIV_W'(2 * STEP_BASE);
				divisor = DIV_W'(sample_rate_q);
			end
		endcase
	end

	cfsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign step_sat = (sample_rate_q == '0) ? 8'd0 : sat8(div_quo);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.div_store) begin
			case (cmd.div_op)
				OP_PER_SEC: per_sec_q <= BAUD_W'(div_quo);
				OP_LEN: begin
					if (per_sec_q == '0) begin
						len_new_q <= '0;
					end else if (div_quo > DIV_W'(LEN_MAX)) begin
						len_new_q <= LEN_W'(LEN_MAX);
					end else begin
						len_new_q <= LEN_W'(div_quo);
					end
				end
				OP_BIT:     bit_new_q <= LEN_W'(div_quo);
				OP_STEP_LO: stl_new_q <= phase_mod(step_sat);
				default:    sth_new_q <= phase_mod(step_sat);
			endcase
		end
	end

	always_comb begin
		running = (period_left_q != '0);
		use_tone = 1'b0;
		use_high = 1'b1;
		if (!running) begin
			use_tone = tone_latch_q;
		end else begin
			case (mode_q)
				SYM_TONE: use_tone = 1'b1;
				SYM_DATA: begin
					use_tone = 1'b1;
					if (spb_q != '0) begin
						if (seg_q == SEG_START) begin
							use_high = 1'b0;
						end else if (seg_q != SEG_STOP) begin
							use_high = byte_q[3'(4'(DATA_BITS) - seg_q)];
						end
					end
				end
				default: use_tone = 1'b0;
			endcase
		end
		step = use_high ? sth_q : stl_q;
		phase_sum = {1'b0, phase_q} + {1'b0, step};
		if (phase_sum >= (PHASE_W+1)'(PHASE_TABLE_SIZE)) begin
			phase_nxt = PHASE_W'(phase_sum - (PHASE_W+1)'(PHASE_TABLE_SIZE));
		end else begin
			phase_nxt = PHASE_W'(phase_sum);
		end
		level = (phase_nxt < PHASE_W'(PHASE_HALF)) ? LEVEL_POS : LEVEL_NEG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			mode_q <= SYM_SILENCE;
			byte_q <= '0;
			period_left_q <= '0;
			spb_q <= '0;
			sub_q <= '0;
			seg_q <= SEG_START;
			stl_q <= '0;
			sth_q <= '0;
			tone_latch_q <= 1'b0;
		end else if (cmd.commit) begin
			case (item_q.symbol)
				SYM_TONE: begin
					mode_q <= SYM_TONE;
					tone_latch_q <= 1'b1;
				end
				SYM_DATA: mode_q <= SYM_DATA;
				default:  mode_q <= SYM_SILENCE;
			endcase
			byte_q <= item_q.data_byte;
			period_left_q <= len_new_q;
			spb_q <= bit_new_q;
			sub_q <= '0;
			seg_q <= SEG_START;
			stl_q <= stl_new_q;
			sth_q <= sth_new_q;
		end else if (cmd.tick) begin
			if (use_tone) begin
				phase_q <= phase_nxt;
			end
			if (running) begin
				period_left_q <= period_left_q - 1'b1;
				if (sub_q == spb_q - 1'b1) begin
					sub_q <= '0;
					if (seg_q != SEG_STOP) begin
						seg_q <= seg_q + 1'b1;
					end
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.tick) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			result_q.sample <= use_tone ? level : 16'sd0;
			result_q.period_end <= running && (period_left_q == LEN_W'(1));
			result_q.idle <= !running;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	assign stat.item_kind = item.kind;
	assign stat.div_done = div_done;
	assign stat.out_free = !result_valid_q || !result_stall;

endmodule

// File: design/cassette_fsk_sample_generator_unit.sv
// Cassette FSK square-wave modulator. A load word (kind 0) sets the next tape
// symbol (silence, leader tone or data byte) and gives no result; a tick word
// (kind 1) gives one signed audio sample of +32767, -32767 or 0. A tick word is
// captured in the idle state and its sample is registered from the tick state,
// which waits while the result register is held by result_stall. While a load
// runs, item_stall stays high: five serial quotients (byte rate, period length,
// bit length, low and high phase step) run one after the other through a single
// restoring divider, each with a start state, 17 quotient bits at one per cycle
// and a store, then a commit state and the return to idle, which takes the next
// word. Registers (sample rate, baud rate, stop bits) are written through the
// cfg port, which never stalls, and take effect at the next load.
module cassette_fsk_sample_generator_unit
	import cfsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	status_t stat;

	cfsg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	cfsg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cmd          (cmd),
		.stat         (stat)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("accepted word did not make the block busy");

	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> item_stall)
		else $error("divider finished while idle");

	a_end_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.idle && result.period_end))
		else $error("filler sample flagged as period end");

endmodule
